// ===== hw/rtl/te_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tuple enumerator package
// Shared widths, configuration layout, controller states and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package te_pkg;

    localparam int MAX_DIGITS    = 8;
    localparam int DIGIT_BITS    = 8;
    localparam int IDX_BITS      = $clog2(MAX_DIGITS);
    localparam int LEN_BITS      = 4;
    localparam int ALT_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef logic [IDX_BITS-1:0]   idx_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ALTERNATIVES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TUPLE_LEN    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SORTED_MODE  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_EQUAL   = 2'd3;

    localparam logic [ALT_BITS-1:0] ALT_RESET = 8'd2;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 4'd2;

    typedef struct packed {
        logic [ALT_BITS-1:0] alternatives;
        logic [LEN_BITS-1:0] tuple_len;
        logic                sorted_mode;
        logic                skip_equal;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FILL,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_first;
        logic walk_init;
        logic zero_cur;
        logic dec_idx;
        logic inc_cur;
        logic fill;
        logic inc_last;
        logic set_done;
        logic load_out;
        logic ok;
    } cmd_t;

    typedef struct packed {
        logic alt_zero;
        logic done;
        logic first_pending;
        logic cur_at_max;
        logic idx_zero;
        logic idx_last;
        logic all_eq;
        logic last_at_max;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/te_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tuple enumerator controller
// Sequences one advance: start decision, carry walk, sorted fill, equal-digit
// check and hand-off of the result word to the output register.
// ----------------------------------------------------------------------------
module te_ctrl
    import te_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire cfg_t    cfg,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   ok_reg;
    logic   ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.alt_zero || status.done || status.first_pending)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.cur_at_max)
                begin
                    if (status.idx_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (cfg.sorted_mode && !status.idx_last)
                begin
                    state_next = ST_FILL;
                end
                else if (cfg.skip_equal)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FILL:
            begin
                if (status.idx_last)
                begin
                    state_next = cfg.skip_equal ? ST_CHECK : ST_FINISH;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        ok_next = ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
            end
            ST_START:
            begin
                if (status.alt_zero || status.done)
                begin
                    ok_next = 1'b0;
                end
                else if (status.first_pending)
                begin
                    cmd.clr_first = 1'b1;
                    ok_next       = 1'b1;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (status.cur_at_max)
                begin
                    cmd.zero_cur = 1'b1;
                    if (status.idx_zero)
                    begin
                        cmd.set_done = 1'b1;
                        ok_next      = 1'b0;
                    end
                    else
                    begin
                        cmd.dec_idx = 1'b1;
                    end
                end
                else
                begin
                    cmd.inc_cur = 1'b1;
                    ok_next     = 1'b1;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
            end
            ST_CHECK:
            begin
                if (status.all_eq)
                begin
                    if (status.last_at_max)
                    begin
                        cmd.set_done = 1'b1;
                        ok_next      = 1'b0;
                    end
                    else
                    begin
                        cmd.inc_last = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                cmd.load_out = status.out_free;
                cmd.ok       = ok_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/te_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tuple enumerator datapath
// Digit registers, walk and pivot indexes, progress flags and the registered
// result word with its valid flag.
// ----------------------------------------------------------------------------
module te_dpath
    import te_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   restart,
    input  wire cmd_t   cmd,
    output status_t     status,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic        has_next,
    output digit_t      out_digits [MAX_DIGITS]
);

    digit_t digits_reg [MAX_DIGITS];
    digit_t res_digits_reg [MAX_DIGITS];
    logic   first_pending_reg;
    logic   done_reg;
    idx_t   idx_reg;
    idx_t   piv_reg;
    logic   out_valid_reg;
    logic   has_next_reg;

    logic [LEN_BITS-1:0] len_eff;
    idx_t                last_idx;
    digit_t              alt_m1;
    logic                all_eq;

    function automatic logic at_max(input digit_t d, input digit_t lim);
        return (d >= lim) || (d == {DIGIT_BITS{1'b1}});
    endfunction

    always_comb
    begin
        if (cfg.tuple_len == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (cfg.tuple_len > LEN_BITS'(MAX_DIGITS))
        begin
            len_eff = LEN_BITS'(MAX_DIGITS);
        end
        else
        begin
            len_eff = cfg.tuple_len;
        end
    end

    assign last_idx = IDX_BITS'(len_eff - LEN_BITS'(1));
    assign alt_m1   = DIGIT_BITS'(cfg.alternatives - ALT_BITS'(1));

    always_comb
    begin
        all_eq = 1'b1;
        for (int k = 1; k < MAX_DIGITS; k++)
        begin
            if ((IDX_BITS'(k) <= last_idx) && (digits_reg[k] != digits_reg[0]))
            begin
                all_eq = 1'b0;
            end
        end
    end

    always_comb
    begin
        status.alt_zero      = (cfg.alternatives == '0);
        status.done          = done_reg;
        status.first_pending = first_pending_reg;
        status.cur_at_max    = at_max(digits_reg[idx_reg], alt_m1);
        status.idx_zero      = (idx_reg == '0);
        status.idx_last      = (idx_reg == last_idx);
        status.all_eq        = all_eq;
        status.last_at_max   = at_max(digits_reg[last_idx], alt_m1);
        status.out_free      = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_DIGITS; k++)
            begin
                digits_reg[k] <= '0;
            end
            first_pending_reg <= 1'b1;
            done_reg          <= 1'b0;
            idx_reg           <= '0;
            piv_reg           <= '0;
        end
        else
        begin
            if (cmd.accept && restart)
            begin
                for (int k = 0; k < MAX_DIGITS; k++)
                begin
                    digits_reg[k] <= '0;
                end
                first_pending_reg <= !cfg.skip_equal;
                done_reg          <= 1'b0;
            end
            if (cmd.clr_first)
            begin
                first_pending_reg <= 1'b0;
            end
            if (cmd.walk_init)
            begin
                idx_reg <= last_idx;
            end
            if (cmd.zero_cur)
            begin
                digits_reg[idx_reg] <= '0;
            end
            if (cmd.dec_idx)
            begin
                idx_reg <= idx_reg - IDX_BITS'(1);
            end
            if (cmd.inc_cur)
            begin
                digits_reg[idx_reg] <= digits_reg[idx_reg] + DIGIT_BITS'(1);
                piv_reg             <= idx_reg;
                idx_reg             <= idx_reg + IDX_BITS'(1);
            end
            if (cmd.fill)
            begin
                digits_reg[idx_reg] <= digits_reg[piv_reg];
                idx_reg             <= idx_reg + IDX_BITS'(1);
            end
            if (cmd.inc_last)
            begin
                digits_reg[last_idx] <= digits_reg[last_idx] + DIGIT_BITS'(1);
            end
            if (cmd.set_done)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            has_next_reg <= cmd.ok;
            for (int k = 0; k < MAX_DIGITS; k++)
            begin
                if (cmd.ok && (LEN_BITS'(k) < len_eff))
                begin
                    res_digits_reg[k] <= digits_reg[k];
                end
                else
                begin
                    res_digits_reg[k] <= '0;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign has_next   = has_next_reg;
    assign out_digits = res_digits_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/tuple_enumerator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tuple enumerator
// Odometer enumeration of digit tuples with optional sorted and skip-equal
// modes; one result word for each request word.
// ----------------------------------------------------------------------------
// Requests are taken one at a time: in_stall stays high from the accepted
// request until its result enters the output register, and the carry walk
// moves one digit per cycle.
// Reset clears the digits, loads the register defaults and empties the output.
module tuple_enumerator
    import te_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     restart,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          has_next,
    output logic [DIGIT_BITS-1:0]         digit_0,
    output logic [DIGIT_BITS-1:0]         digit_1,
    output logic [DIGIT_BITS-1:0]         digit_2,
    output logic [DIGIT_BITS-1:0]         digit_3,
    output logic [DIGIT_BITS-1:0]         digit_4,
    output logic [DIGIT_BITS-1:0]         digit_5,
    output logic [DIGIT_BITS-1:0]         digit_6,
    output logic [DIGIT_BITS-1:0]         digit_7
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    digit_t  out_digits [MAX_DIGITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alternatives <= ALT_RESET;
            cfg_reg.tuple_len    <= LEN_RESET;
            cfg_reg.sorted_mode  <= 1'b0;
            cfg_reg.skip_equal   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALTERNATIVES: cfg_reg.alternatives <= cfg_data[ALT_BITS-1:0];
                CFG_TUPLE_LEN:    cfg_reg.tuple_len    <= cfg_data[LEN_BITS-1:0];
                CFG_SORTED_MODE:  cfg_reg.sorted_mode  <= cfg_data[0];
                CFG_SKIP_EQUAL:   cfg_reg.skip_equal   <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    te_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg      (cfg_reg),
        .status   (status),
        .cmd      (cmd)
    );

    te_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .restart    (restart),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .has_next   (has_next),
        .out_digits (out_digits)
    );

    assign digit_0 = out_digits[0];
    assign digit_1 = out_digits[1];
    assign digit_2 = out_digits[2];
    assign digit_3 = out_digits[3];
    assign digit_4 = out_digits[4];
    assign digit_5 = out_digits[5];
    assign digit_6 = out_digits[6];
    assign digit_7 = out_digits[7];

endmodule
`default_nettype wire

// ===== test/tuple_enumerator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuple enumerator testbench
// Drives request words with random restarts and random pacing on both sides,
// changes the registers between phases, and checks every result word against
// an odometer model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tuple_enumerator_test;
    import te_pkg::*;

    typedef struct packed {
        logic                         has_next;
        digit_t [MAX_DIGITS-1:0]      digits;
    } tuple_word_t;

    class odometer_ledger;
        logic [ALT_BITS-1:0] alt_count;
        logic [LEN_BITS-1:0] len_reg;
        bit                  sort_fill;
        bit                  drop_level;
        digit_t              wheel[MAX_DIGITS];
        bit                  fresh;
        bit                  spent;
        tuple_word_t         due_q[$];
        int                  errors;
        int                  shown;
        int                  presented;
        int                  exhausted;

        function new();
            alt_count  = ALT_RESET;
            len_reg    = LEN_RESET;
            sort_fill  = 1'b0;
            drop_level = 1'b0;
            errors     = 0;
            shown      = 0;
            presented  = 0;
            exhausted  = 0;
            rewind();
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_ALTERNATIVES: alt_count  = data[ALT_BITS-1:0];
                CFG_TUPLE_LEN:    len_reg    = data[LEN_BITS-1:0];
                CFG_SORTED_MODE:  sort_fill  = data[0];
                CFG_SKIP_EQUAL:   drop_level = data[0];
                default:          ;
            endcase
        endfunction

        function void rewind();
            for (int k = 0; k < MAX_DIGITS; k++)
                wheel[k] = '0;
            fresh = !drop_level;
            spent = 1'b0;
        endfunction

        function int span();
            if (len_reg == 0)
                return 1;
            if (len_reg > MAX_DIGITS)
                return MAX_DIGITS;
            return int'(len_reg);
        endfunction

        // A digit at or past the last value, or at its storage limit, carries.
        function bit topped(digit_t d);
            return (alt_count != 0 && int'(d) >= int'(alt_count) - 1) || d == '1;
        endfunction

        function bit turn();
            int len;
            int i;
            len = span();
            i = len - 1;
            while (topped(wheel[i]))
            begin
                wheel[i] = '0;
                if (i == 0)
                begin
                    spent = 1'b1;
                    return 1'b0;
                end
                i--;
            end
            wheel[i] = wheel[i] + 1'b1;
            if (sort_fill)
                for (int j = i + 1; j < len; j++)
                    wheel[j] = wheel[i];
            if (drop_level)
            begin
                for (int j = 1; j < len; j++)
                    if (wheel[j] != wheel[0])
                        return 1'b1;
                if (topped(wheel[len-1]))
                begin
                    spent = 1'b1;
                    return 1'b0;
                end
                wheel[len-1] = wheel[len-1] + 1'b1;
            end
            return 1'b1;
        endfunction

        function void note_request(bit rs);
            tuple_word_t w;
            bit          ok;
            int          len;
            if (rs)
                rewind();
            if (alt_count == 0 || spent)
                ok = 1'b0;
            else if (fresh)
            begin
                fresh = 1'b0;
                ok = 1'b1;
            end
            else
                ok = turn();
            len = span();
            w.has_next = ok;
            for (int k = 0; k < MAX_DIGITS; k++)
                w.digits[k] = (ok && k < len) ? wheel[k] : '0;
            due_q.push_back(w);
        endfunction

        function int due();
            return due_q.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (shown < 100)
            begin
                shown++;
                $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
            end
        endtask

        task check_tuple(tuple_word_t got);
            tuple_word_t want;
            if (due_q.size() == 0)
            begin
                report_mismatch("result word with none expected, has_next", got.has_next, 0);
                return;
            end
            want = due_q.pop_front();
            if (want.has_next)
                presented++;
            else
                exhausted++;
            if (got.has_next !== want.has_next)
                report_mismatch("has_next", got.has_next, want.has_next);
            for (int k = 0; k < MAX_DIGITS; k++)
                if (got.digits[k] !== want.digits[k])
                    report_mismatch($sformatf("digit_%0d", k), got.digits[k], want.digits[k]);
        endtask

        task flag_leftovers();
            while (due_q.size() != 0)
                report_mismatch("missing result word, has_next", -1, due_q.pop_front().has_next);
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     restart = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     has_next;
    logic [DIGIT_BITS-1:0]    digit_0, digit_1, digit_2, digit_3;
    logic [DIGIT_BITS-1:0]    digit_4, digit_5, digit_6, digit_7;

    odometer_ledger ledger = new();
    bit             source_lazy = 1'b1;
    bit             sink_lazy = 1'b1;
    int             sent = 0;
    int             restarts = 0;
    int             writes = 0;
    int             phases = 0;

    tuple_enumerator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .has_next  (has_next),
        .digit_0   (digit_0),
        .digit_1   (digit_1),
        .digit_2   (digit_2),
        .digit_3   (digit_3),
        .digit_4   (digit_4),
        .digit_5   (digit_5),
        .digit_6   (digit_6),
        .digit_7   (digit_7)
    );

    always #5 clk = ~clk;

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        ledger.set_register(idx, data);
        writes++;
    endtask

    task automatic configure(bit [3:0] which, logic [ALT_BITS-1:0] alt,
                             logic [LEN_BITS-1:0] len, bit srt, bit skp);
        logic [CFG_DATA_BITS-1:0] word;
        if (which[CFG_ALTERNATIVES])
            write_reg(CFG_ALTERNATIVES, alt);
        if (which[CFG_TUPLE_LEN])
        begin
            word = CFG_DATA_BITS'($urandom_range(0, 255));
            word[LEN_BITS-1:0] = len;
            write_reg(CFG_TUPLE_LEN, word);
        end
        if (which[CFG_SORTED_MODE])
        begin
            word = CFG_DATA_BITS'($urandom_range(0, 255));
            word[0] = srt;
            write_reg(CFG_SORTED_MODE, word);
        end
        if (which[CFG_SKIP_EQUAL])
        begin
            word = CFG_DATA_BITS'($urandom_range(0, 255));
            word[0] = skp;
            write_reg(CFG_SKIP_EQUAL, word);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_request(bit rs);
        int gap;
        gap = source_lazy ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do @(posedge clk); while (in_stall);
        ledger.note_request(rs);
        sent++;
        if (rs)
            restarts++;
        @(negedge clk);
    endtask

    task automatic settle();
        int spin;
        spin = 0;
        while (ledger.due() != 0 && spin < 4000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (24) @(negedge clk);
    endtask

    task automatic run_phase(int count, bit lead_restart, int restart_odds);
        bit rs;
        for (int n = 0; n < count; n++)
        begin
            if (n == 0)
                rs = lead_restart;
            else
                rs = restart_odds != 0 && $urandom_range(1, restart_odds) == 1;
            send_request(rs);
        end
        in_valid <= 1'b0;
        settle();
        phases++;
    endtask

    initial
    begin
        tuple_word_t got;
        int          lull;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            lull = sink_lazy ? $urandom_range(0, 11) : 0;
            if (lull > 0)
            begin
                out_stall <= 1'b1;
                repeat (lull) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got.has_next = has_next;
            got.digits = {digit_7, digit_6, digit_5, digit_4,
                          digit_3, digit_2, digit_1, digit_0};
            ledger.check_tuple(got);
            @(negedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          goal;
        int          pick;
        logic [7:0]  alt;
        logic [3:0]  len;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part: register defaults, exhaustion, zero alternatives,
        // length extremes, both modes, and alternatives lowered mid-run.
        run_phase(6, 1'b0, 0);
        run_phase(2, 1'b1, 0);
        configure(4'b0001, 8'd0, 4'd0, 1'b0, 1'b0);
        run_phase(2, 1'b1, 0);
        configure(4'b1111, 8'd255, 4'd15, 1'b1, 1'b1);
        run_phase(3, 1'b1, 0);
        configure(4'b1111, 8'd1, 4'd0, 1'b0, 1'b0);
        run_phase(2, 1'b1, 0);
        configure(4'b1111, 8'd3, 4'd3, 1'b1, 1'b0);
        run_phase(4, 1'b1, 0);
        configure(4'b0001, 8'd2, 4'd0, 1'b0, 1'b0);
        run_phase(3, 1'b0, 0);
        configure(4'b1111, 8'd255, 4'd1, 1'b0, 1'b1);
        run_phase(2, 1'b1, 0);

        goal = sent + 1900;
        while (sent < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                alt = 8'd0;
            else if (pick <= 6)
                alt = 8'($urandom_range(1, 4));
            else if (pick <= 8)
                alt = 8'($urandom_range(5, 255));
            else
                alt = 8'd255;
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                len = 4'($urandom_range(1, 4));
            else if (pick == 7)
                len = 4'd0;
            else if (pick == 8)
                len = 4'($urandom_range(9, 15));
            else
                len = 4'($urandom_range(5, 8));
            source_lazy = $urandom_range(0, 3) != 0;
            sink_lazy   = $urandom_range(0, 3) != 0;
            configure($urandom_range(0, 3) == 0 ? 4'($urandom_range(1, 15)) : 4'b1111,
                      alt, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            run_phase($urandom_range(10, 60), $urandom_range(0, 4) != 0, 30);
        end

        settle();
        ledger.flag_leftovers();
        $display("tb: %0d requests in %0d phases, %0d restarts, %0d register writes",
                 sent, phases, restarts, writes);
        $display("tb: %0d tuples presented, %0d exhausted answers, %0d mismatches",
                 ledger.presented, ledger.exhausted, ledger.errors);
        if (ledger.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
